// File: rtl/matrix_multiply_engine_assert.svh
// Assertion macros shared by the engine's modules.
// They expect signals named clock and reset in the scope where they are used.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define MME_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mme_pkg.sv
package mme_pkg;

   localparam int MAX_DIM      = 16;
   localparam int ELEMENT_BITS = 16;

   localparam int DIM_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_BITS  = $clog2(MAX_DIM + 1);
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int PROD_BITS = 2 * ELEMENT_BITS;
   localparam int SUM_BITS  = 36;
   localparam int WIDE_BITS = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;

   // fixed field widths
   localparam int OP_BITS    = 2;
   localparam int INDEX_BITS = 4;
   localparam int VALUE_BITS = 16;
   localparam int CFG_BITS   = 5;
   localparam int CSR_BITS   = 2;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE_LEFT  = 2'd0,
      OP_WRITE_RIGHT = 2'd1,
      OP_READ        = 2'd2
   } op_type;

   localparam logic [CSR_BITS-1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_INNER_COUNT = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_COL_COUNT   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic                accept;      // input item taken this cycle
      logic                start_read;  // latch indices, clear accumulator
      logic                issue;       // read one left/right element pair
      logic [DIM_BITS-1:0] issue_k;     // inner position of that pair
      logic                load_out;    // move result into output register
      logic                load_err;    // result is an index error
   } mme_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                read_in_range;
      logic [CNT_BITS-1:0] inner_count;
      logic                out_free;
   } mme_status_type;

   // register value clamped to MAX_DIM
   function automatic logic [CNT_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] v);
      return (32'(v) > MAX_DIM) ? CNT_BITS'(MAX_DIM) : CNT_BITS'(v);
   endfunction

   function automatic logic below(input logic [INDEX_BITS-1:0] idx,
                                  input logic [CNT_BITS-1:0]   lim);
      return 32'(idx) < 32'(lim);
   endfunction

   // row-major store address
   function automatic logic [ADDR_BITS-1:0] make_addr(input int unsigned row,
                                                      input int unsigned col);
      return ADDR_BITS'(row * MAX_DIM + col);
   endfunction

endpackage

// File: rtl/mme_ram.sv
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mme_ctrl.sv
`include "matrix_multiply_engine_assert.svh"

module mme_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [mme_pkg::OP_BITS-1:0] req_op,
   input  mme_pkg::mme_status_type status,
   output mme_pkg::mme_cmd_type    cmd
);
   import mme_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT_A,
      ST_WAIT_B,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [DIM_BITS-1:0] k_ff, k_in;
   logic                err_ff, err_in;
   logic                last_k;

   assign last_k = (32'(k_ff) + 32'd1) == 32'(status.inner_count);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      err_in   = err_ff;
      cmd      = '0;
      cmd.issue_k  = k_ff;
      cmd.load_err = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && !reset;
            if (cmd.accept && (req_op == OP_READ)) begin
               cmd.start_read = 1'b1;
               k_in = '0;
               if (!status.read_in_range) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (status.inner_count == '0) begin
                  err_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (last_k) begin
               state_in = ST_WAIT_A;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WAIT_A: state_in = ST_WAIT_B;
         ST_WAIT_B: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         err_ff   <= err_in;
      end
   end

   // no item is taken while reset is high
   assign req_stall = reset || (state_ff != ST_IDLE);

   `MME_ASSERT_IMPLY(a_issue_in_bounds, cmd.issue,
      32'(cmd.issue_k) < 32'(status.inner_count), "issue past inner size")
   `MME_ASSERT_IMPLY(a_load_when_free, cmd.load_out, status.out_free,
      "result loaded over a waiting item")
   `MME_ASSERT_NEXT(a_err_skips_run, cmd.start_read && !status.read_in_range,
      state_ff == ST_FINISH && err_ff, "index error did not go to finish")

endmodule

// File: rtl/mme_datapath.sv
`include "matrix_multiply_engine_assert.svh"

module mme_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mme_pkg::mme_cmd_type                  cmd,
   output mme_pkg::mme_status_type               status,
   input  logic [mme_pkg::OP_BITS-1:0]           req_op,
   input  logic [mme_pkg::INDEX_BITS-1:0]        req_row_index,
   input  logic [mme_pkg::INDEX_BITS-1:0]        req_col_index,
   input  logic signed [mme_pkg::VALUE_BITS-1:0] req_element_value,
   input  logic                                  csr_write_enable,
   input  logic [mme_pkg::CSR_BITS-1:0]          csr_index,
   input  logic [mme_pkg::CFG_BITS-1:0]          csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mme_pkg::SUM_BITS-1:0]   rsp_product_value,
   output logic                                  rsp_index_error
);
   import mme_pkg::*;

   logic [CFG_BITS-1:0] row_count_ff, inner_count_ff, col_count_ff;
   logic [CNT_BITS-1:0] nr, ni, nc;

   logic [INDEX_BITS-1:0] row_ff, col_ff;

   logic signed [ELEMENT_BITS-1:0] elem;
   logic                           wr_left, wr_right;
   logic [ADDR_BITS-1:0]           wr_addr, rd_addr_left, rd_addr_right;
   logic [ELEMENT_BITS-1:0]        left_data, right_data;

   logic                        rd_valid_ff, prod_valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [SUM_BITS-1:0]  acc_ff;
   logic signed [WIDE_BITS-1:0] sum_wide;
   logic signed [SUM_BITS-1:0]  acc_in;
   logic                        ovf;

   logic                       rsp_valid_ff;
   logic signed [SUM_BITS-1:0] rsp_product_value_ff;
   logic                       rsp_index_error_ff;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= CFG_RESET;
         inner_count_ff <= CFG_RESET;
         col_count_ff   <= CFG_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ROW_COUNT)   row_count_ff   <= csr_write_data;
         if (csr_index == CSR_INNER_COUNT) inner_count_ff <= csr_write_data;
         if (csr_index == CSR_COL_COUNT)   col_count_ff   <= csr_write_data;
      end
   end

   assign nr = eff_size(row_count_ff);
   assign ni = eff_size(inner_count_ff);
   assign nc = eff_size(col_count_ff);

   assign status.read_in_range = below(req_row_index, nr) && below(req_col_index, nc);
   assign status.inner_count   = ni;
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   // element writes
   assign elem     = ELEMENT_BITS'(req_element_value);
   assign wr_addr  = make_addr(32'(req_row_index), 32'(req_col_index));
   assign wr_left  = cmd.accept && (req_op == OP_WRITE_LEFT)
                     && below(req_row_index, nr) && below(req_col_index, ni);
   assign wr_right = cmd.accept && (req_op == OP_WRITE_RIGHT)
                     && below(req_row_index, ni) && below(req_col_index, nc);

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
      end
   end

   assign rd_addr_left  = make_addr(32'(row_ff), 32'(cmd.issue_k));
   assign rd_addr_right = make_addr(32'(cmd.issue_k), 32'(col_ff));

   mme_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (wr_left),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr_left),
      .rd_data (left_data)
   );

   mme_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (wr_right),
      .wr_addr (wr_addr),
      .wr_data (elem),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr_right),
      .rd_data (right_data)
   );

   // multiply stage, then saturating accumulate
   assign sum_wide = WIDE_BITS'(acc_ff) + WIDE_BITS'(prod_ff);
   assign ovf      = (sum_wide[WIDE_BITS-1:SUM_BITS-1] != '0)
                     && (sum_wide[WIDE_BITS-1:SUM_BITS-1] != '1);
   assign acc_in   = !ovf ? sum_wide[SUM_BITS-1:0]
                   : sum_wide[WIDE_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                   : {1'b0, {(SUM_BITS-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prod_ff <= signed'(left_data) * signed'(right_data);
      end
      if (cmd.start_read) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_product_value_ff <= cmd.load_err ? '0 : acc_ff;
         rsp_index_error_ff   <= cmd.load_err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_product_value_ff;
   assign rsp_index_error   = rsp_index_error_ff;

   `MME_ASSERT_IMPLY(a_err_gives_zero, rsp_valid_ff && rsp_index_error_ff,
      rsp_product_value_ff == '0, "index error with nonzero product")

endmodule

// File: rtl/matrix_multiply_engine.sv
// Dense matrix multiply engine. Left (row_count x inner_count) and right
// (inner_count x col_count) matrices of signed Q8.8 elements are loaded one
// element per item (op 0 left, op 1 right); op 2 returns one product entry as
// a signed Q20.16 dot product, saturated to 36 bits. Writes outside the sizes
// are dropped; reads outside them return index_error with a zero value. Sizes
// above MAX_DIM act as MAX_DIM. After a write item the next item is taken in
// the following cycle. A read stalls the input through the inner steps and
// wait states A and B (skipped on an index error or zero inner size), then
// finish, where its result enters the output register once the last one has
// left it; one multiply-accumulate unit fed by one read port per element store
// does one inner step per cycle. New items are taken while a result waits in
// the output register. The input is stalled while reset is high. Stores are not
// cleared at reset: only entries written since then may be read.
module matrix_multiply_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mme_pkg::OP_BITS-1:0]           req_op,
   input  logic [mme_pkg::INDEX_BITS-1:0]        req_row_index,
   input  logic [mme_pkg::INDEX_BITS-1:0]        req_col_index,
   input  logic signed [mme_pkg::VALUE_BITS-1:0] req_element_value,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mme_pkg::SUM_BITS-1:0]   rsp_product_value,
   output logic                                  rsp_index_error,
   // size registers: 0 row_count, 1 inner_count, 2 col_count
   input  logic                                  csr_write_enable,
   input  logic [mme_pkg::CSR_BITS-1:0]          csr_index,
   input  logic [mme_pkg::CFG_BITS-1:0]          csr_write_data
);
   import mme_pkg::*;

   mme_cmd_type    cmd;
   mme_status_type status;

   // sequencer: accepts items, steps the inner index, hands off results
   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, multiply-accumulate, size registers and output register
   mme_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_index_error   (rsp_index_error)
   );

endmodule

// File: tb/sv/matrix_multiply_engine_tb.sv
`timescale 1ns / 100ps

module matrix_multiply_engine_tb;
   import mme_pkg::*;

   // codes the block does not define; both must be ignored
   localparam logic [OP_BITS-1:0]  OP_UNUSED  = 2'd3;
   localparam logic [CSR_BITS-1:0] CSR_UNUSED = 2'd3;

   // 36-bit signed accumulator range
   localparam longint SUM_HI = 64'sd34359738367;
   localparam longint SUM_LO = -SUM_HI - 1;

   localparam int RANDOM_ITEMS = 1000;
   localparam int PHASES       = 10;

   typedef struct {
      logic signed [SUM_BITS-1:0] product;
      logic                       index_error;
   } product_entry_type;

   // one line of the directed plan: an item, or a size register write
   typedef enum bit {STEP_ITEM, STEP_SIZE} step_kind_type;
   typedef struct {
      step_kind_type                kind;
      logic [1:0]                   code;        // op for items, register index for sizes
      logic [INDEX_BITS-1:0]        row;
      logic [INDEX_BITS-1:0]        col;
      logic signed [VALUE_BITS-1:0] value;
      bit                           typed;       // expected result given in the row
      logic signed [SUM_BITS-1:0]   product;
      logic                         index_error;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   logic                         req_valid;
   logic                         req_stall;
   logic [OP_BITS-1:0]           req_op;
   logic [INDEX_BITS-1:0]        req_row_index;
   logic [INDEX_BITS-1:0]        req_col_index;
   logic signed [VALUE_BITS-1:0] req_element_value;

   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [SUM_BITS-1:0]   rsp_product_value;
   logic                         rsp_index_error;

   logic                         csr_write_enable;
   logic [CSR_BITS-1:0]          csr_index;
   logic [CFG_BITS-1:0]          csr_write_data;

   matrix_multiply_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_value (rsp_product_value),
      .rsp_index_error   (rsp_index_error),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the block: both element stores, which entries hold data,
   // and the three size registers (reset value 16).
   // ------------------------------------------------------------------
   logic signed [VALUE_BITS-1:0] left_mem  [DEPTH];
   logic signed [VALUE_BITS-1:0] right_mem [DEPTH];
   bit                           left_seen [DEPTH];
   bit                           right_seen[DEPTH];
   logic [CFG_BITS-1:0]          row_reg   = CFG_RESET;
   logic [CFG_BITS-1:0]          inner_reg = CFG_RESET;
   logic [CFG_BITS-1:0]          col_reg   = CFG_RESET;

   product_entry_type product_queue[$];   // results still owed by the block, oldest first
   product_entry_type oldest;
   int unsigned       mismatch_count = 0;
   int unsigned       items_sent;
   bit                feed_pace  = 1'b1;  // sender idles between items
   bit                drain_pace = 1'b1;  // receiver stalls before taking results

   // sizes above MAX_DIM behave as MAX_DIM
   function automatic int unsigned clamp_size(input logic [CFG_BITS-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   // random Q8.8 element, with the extremes and zero turning up often
   function automatic logic signed [VALUE_BITS-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic step_type item_row(input logic [OP_BITS-1:0] op,
                                         input logic [INDEX_BITS-1:0] r, c,
                                         input logic signed [VALUE_BITS-1:0] v);
      step_type s;
      s = '{STEP_ITEM, op, r, c, v, 1'b0, 36'sd0, 1'b0};
      return s;
   endfunction

   function automatic step_type read_row(input logic [INDEX_BITS-1:0] r, c,
                                         input logic signed [SUM_BITS-1:0] prod,
                                         input logic err);
      step_type s;
      s = '{STEP_ITEM, OP_READ, r, c, 16'sd0, 1'b1, prod, err};
      return s;
   endfunction

   function automatic step_type size_row(input logic [CSR_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] val);
      step_type s;
      s = '{STEP_SIZE, idx, 4'd0, 4'd0, VALUE_BITS'(val), 1'b0, 36'sd0, 1'b0};
      return s;
   endfunction

   // Size register write. Only done with nothing in flight: every owed
   // result has come back, then a pause covering a full-length read.
   task automatic write_size(input logic [CSR_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      req_valid = 1'b0;
      while (product_queue.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_ROW_COUNT:   row_reg   = val;
         CSR_INNER_COUNT: inner_reg = val;
         CSR_COL_COUNT:   col_reg   = val;
         default: ;
      endcase
   endtask

   // Present one item, hold it until taken, then update the shadow stores
   // or work out the product entry the block owes. Called at a falling edge;
   // returns at a falling edge with valid still high, so a back-to-back item
   // simply replaces the payload.
   task automatic send_item(input logic [OP_BITS-1:0] op,
                            input logic [INDEX_BITS-1:0] r, c,
                            input logic signed [VALUE_BITS-1:0] v,
                            input bit typed = 1'b0,
                            input logic signed [SUM_BITS-1:0] prod = 36'sd0,
                            input logic err = 1'b0);
      int unsigned       gap;
      int unsigned       nr, ni, nc;
      longint            acc;
      product_entry_type entry;
      gap = feed_pace ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op            = op;
      req_row_index     = r;
      req_col_index     = c;
      req_element_value = v;
      req_valid         = 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      items_sent++;
      nr = clamp_size(row_reg);
      ni = clamp_size(inner_reg);
      nc = clamp_size(col_reg);
      case (op)
         OP_WRITE_LEFT: begin
            if (r < nr && c < ni) begin
               left_mem[r * MAX_DIM + c]  = v;
               left_seen[r * MAX_DIM + c] = 1'b1;
            end
         end
         OP_WRITE_RIGHT: begin
            if (r < ni && c < nc) begin
               right_mem[r * MAX_DIM + c]  = v;
               right_seen[r * MAX_DIM + c] = 1'b1;
            end
         end
         OP_READ: begin
            // dot product of left row r and right column c, saturating sum
            entry.index_error = (r >= nr || c >= nc);
            acc = 0;
            if (!entry.index_error) begin
               for (int k = 0; k < ni; k++) begin
                  acc += longint'(left_mem[r * MAX_DIM + k]) *
                         longint'(right_mem[k * MAX_DIM + c]);
                  if (acc > SUM_HI) acc = SUM_HI;
                  else if (acc < SUM_LO) acc = SUM_LO;
               end
            end
            entry.product = acc[SUM_BITS-1:0];
            if (typed) begin
               entry.product     = prod;
               entry.index_error = err;
            end
            product_queue.push_back(entry);
         end
         default: ;   // unused op: dropped, no result
      endcase
      @(negedge clock);
   endtask

   // Receiver: per result, stall a random number of cycles, then take it.
   initial begin
      int unsigned hold_cycles;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold_cycles = drain_pace ? $urandom_range(0, 19) : 0;
         if (hold_cycles != 0) begin
            rsp_stall = 1'b1;
            repeat (hold_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Result checker: every taken result against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (product_queue.size() == 0) begin
            $error("unexpected result: product_value %0d index_error %0b",
                   rsp_product_value, rsp_index_error);
            mismatch_count++;
         end else begin
            oldest = product_queue.pop_front();
            if (rsp_product_value !== oldest.product) begin
               $error("product_value: expected %0d, got %0d",
                      oldest.product, rsp_product_value);
               mismatch_count++;
            end
            if (rsp_index_error !== oldest.index_error) begin
               $error("index_error: expected %0b, got %0b",
                      oldest.index_error, rsp_index_error);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      step_type              plan[$];
      logic [CFG_BITS-1:0]   rows, inners, cols;
      logic [OP_BITS-1:0]    op;
      logic [INDEX_BITS-1:0] r, c;
      int unsigned           pick, nr, ni, nc;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_WRITE_LEFT;
      req_row_index     = '0;
      req_col_index     = '0;
      req_element_value = '0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_ROW_COUNT;
      csr_write_data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Inner size 1 first so a single element per side
      // makes an entry readable; products of the Q8.8 extremes.
      plan.push_back(size_row(CSR_INNER_COUNT, 5'd1));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd0, 4'd0, 16'h7FFF));
      plan.push_back(item_row(OP_WRITE_RIGHT, 4'd0, 4'd0, 16'h7FFF));
      plan.push_back(read_row(4'd0, 4'd0, 36'sd1073676289, 1'b0));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd15, 4'd0, 16'h8000));
      plan.push_back(item_row(OP_WRITE_RIGHT, 4'd0, 4'd15, 16'h8000));
      plan.push_back(read_row(4'd15, 4'd15, 36'sd1073741824, 1'b0));
      plan.push_back(read_row(4'd15, 4'd0, -36'sd1073709056, 1'b0));
      // unused op, and writes past the inner size: all dropped
      plan.push_back(item_row(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd0, 4'd1, 16'h1234));
      plan.push_back(item_row(OP_WRITE_RIGHT, 4'd1, 4'd0, 16'h1234));
      // reads outside the sizes
      plan.push_back(size_row(CSR_COL_COUNT, 5'd15));
      plan.push_back(read_row(4'd0, 4'd15, 36'sd0, 1'b1));
      plan.push_back(size_row(CSR_ROW_COUNT, 5'd0));
      plan.push_back(read_row(4'd0, 4'd0, 36'sd0, 1'b1));
      // oversize register saturates; zero inner size gives the empty sum
      plan.push_back(size_row(CSR_ROW_COUNT, 5'd31));
      plan.push_back(size_row(CSR_INNER_COUNT, 5'd0));
      plan.push_back(read_row(4'd15, 4'd14, 36'sd0, 1'b0));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd0, 4'd0, 16'h0001));
      // a write to a register index that does not exist changes nothing
      plan.push_back(size_row(CSR_UNUSED, 5'd0));
      plan.push_back(size_row(CSR_INNER_COUNT, 5'd2));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd0, 4'd1, 16'h0080));
      plan.push_back(item_row(OP_WRITE_RIGHT, 4'd1, 4'd0, 16'hFF00));
      plan.push_back(item_row(OP_WRITE_LEFT, 4'd15, 4'd1, 16'h0100));
      plan.push_back(item_row(OP_READ, 4'd0, 4'd0, 16'h0000));
      plan.push_back(item_row(OP_READ, 4'd15, 4'd0, 16'h0000));

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_SIZE) begin
            write_size(plan[i].code, plan[i].value[CFG_BITS-1:0]);
         end else begin
            send_item(plan[i].code, plan[i].row, plan[i].col, plan[i].value,
                      plan[i].typed, plan[i].product, plan[i].index_error);
         end
      end

      // Random part: one size setting per phase, extremes first.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: {rows, inners, cols} = {5'd16, 5'd16, 5'd16};
            1: {rows, inners, cols} = {5'd1,  5'd1,  5'd1};
            2: {rows, inners, cols} = {5'd31, 5'd31, 5'd31};
            3: {rows, inners, cols} = {5'd0,  5'd16, 5'd16};
            4: {rows, inners, cols} = {5'd16, 5'd0,  5'd16};
            5: {rows, inners, cols} = {5'd16, 5'd16, 5'd0};
            6: {rows, inners, cols} = {5'd3,  5'd5,  5'd2};
            default: begin
               rows   = $urandom_range(0, 1) ? CFG_BITS'($urandom_range(1, 16))
                                             : CFG_BITS'($urandom_range(0, 31));
               inners = $urandom_range(0, 1) ? CFG_BITS'($urandom_range(1, 16))
                                             : CFG_BITS'($urandom_range(0, 31));
               cols   = $urandom_range(0, 1) ? CFG_BITS'($urandom_range(1, 16))
                                             : CFG_BITS'($urandom_range(0, 31));
            end
         endcase
         write_size(CSR_ROW_COUNT, rows);
         write_size(CSR_INNER_COUNT, inners);
         write_size(CSR_COL_COUNT, cols);
         // some phases run flat out on one or both sides
         feed_pace  = ($urandom_range(0, 3) != 0);
         drain_pace = ($urandom_range(0, 3) != 0);
         nr = clamp_size(row_reg);
         ni = clamp_size(inner_reg);
         nc = clamp_size(col_reg);

         items_sent = 0;
         while (items_sent < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            r    = INDEX_BITS'($urandom_range(0, 15));
            c    = INDEX_BITS'($urandom_range(0, 15));
            if (pick < 40) begin
               op = OP_WRITE_LEFT;
               if (nr != 0 && ni != 0) begin
                  r = INDEX_BITS'($urandom_range(0, nr - 1));
                  c = INDEX_BITS'($urandom_range(0, ni - 1));
               end
            end else if (pick < 70) begin
               op = OP_WRITE_RIGHT;
               if (ni != 0 && nc != 0) begin
                  r = INDEX_BITS'($urandom_range(0, ni - 1));
                  c = INDEX_BITS'($urandom_range(0, nc - 1));
               end
            end else if (pick < 92) begin
               op = OP_READ;
               if (nr != 0 && nc != 0 && $urandom_range(0, 4) != 0) begin
                  r = INDEX_BITS'($urandom_range(0, nr - 1));
                  c = INDEX_BITS'($urandom_range(0, nc - 1));
               end
            end else begin
               op = OP_BITS'($urandom_range(0, 3));   // noise, mostly dropped or out of range
            end
            // stores are undefined until written: fill whatever the read
            // will touch before asking for the entry
            if (op == OP_READ && r < nr && c < nc) begin
               for (int k = 0; k < ni; k++) begin
                  if (!left_seen[r * MAX_DIM + k])
                     send_item(OP_WRITE_LEFT, r, INDEX_BITS'(k), draw_element());
                  if (!right_seen[k * MAX_DIM + c])
                     send_item(OP_WRITE_RIGHT, INDEX_BITS'(k), c, draw_element());
               end
            end
            send_item(op, r, c, draw_element());
         end
      end

      req_valid = 1'b0;
      while (product_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS matrix_multiply_engine");
      end else begin
         $display("FAIL matrix_multiply_engine");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL matrix_multiply_engine");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/mme_pkg.sv
rtl/mme_ram.sv
rtl/mme_ctrl.sv
rtl/mme_datapath.sv
rtl/matrix_multiply_engine.sv
tb/sv/matrix_multiply_engine_tb.sv
